### hw/rtl/pgm_pkg.sv
// package for the prewitt gradient magnitude core
// holds the controller state type, register indexes and fixed field widths; no dependencies
`default_nettype none

package pgm_pkg;

	// fixed field widths
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned CFG_W     = 11;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned COORD_W   = 10;
	localparam int unsigned SQ_W      = 20;
	localparam int unsigned SUM_W     = 21;
	localparam int unsigned ROOT_W    = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// register reset values and clamp floor
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
	localparam int unsigned      MIN_DIM      = 3;

	// saturated magnitude
	localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_WIN,
		S_MUL,
		S_SQRT_GO,
		S_SQRT_WAIT,
		S_OUT_I,
		S_OUT_B
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/prewitt_gradient_magnitude_core.sv
// Prewitt gradient magnitude core. Pixels enter in raster order, one beat at a time; two line
// rams (one read and one write port each) hold the two rows above, and a 3x3 register window
// feeds the gradient sums. Depends on pgm_pkg, pgm_ram and pgm_sqrt.
//
// One pixel is handled at a time. A pixel that gives no result passes through the window
// update only, a pixel that gives only a border result goes on to the border output, and a
// pixel that gives an interior result goes through the multiply, the 8-step iterative square
// root and the interior output (then the border output, if it gives a border result as well);
// when the sum of squares reaches 65536 the root saturates at once, without the root steps.
// The output side can hold off either output. Border pixels give magnitude 0 at once, an
// interior pixel's result comes out with the pixel one row and one column later, ahead of that
// pixel's own border result. Configuration writes are taken in any cycle and are meant to
// happen while no pixel is in flight. Line ram contents are undefined until a row is seen.
`default_nettype none

module prewitt_gradient_magnitude_core #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// pixel input
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic [pgm_pkg::PIX_W-1:0]         pixel,
	input  wire logic                              frame_start,
	// result output
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic [pgm_pkg::COORD_W-1:0]       out_row,
	output      logic [pgm_pkg::COORD_W-1:0]       out_col,
	output      logic [pgm_pkg::PIX_W-1:0]         magnitude,
	output      logic                              run_last,
	output      logic                              frame_done,
	// configuration writes
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [pgm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pgm_pkg::CFG_W-1:0]         cfg_data
);

	localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned DW_W  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned DH_W  = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned XW_W  = (DW_W > pgm_pkg::CFG_W) ? DW_W : pgm_pkg::CFG_W;
	localparam int unsigned XH_W  = (DH_W > pgm_pkg::CFG_W) ? DH_W : pgm_pkg::CFG_W;
	localparam int unsigned PSUM_W = pgm_pkg::PIX_W + 2;
	localparam int unsigned DIFF_W = PSUM_W + 1;

	pgm_pkg::state_t state_q, state_d;

	logic [pgm_pkg::CFG_W-1:0] width_q, height_q;
	logic [COL_W-1:0]          col_q;
	logic [ROW_W-1:0]          row_q;

	logic [pgm_pkg::PIX_W-1:0] win_q [9];
	logic [pgm_pkg::PIX_W-1:0] px_s1;
	logic [COL_W-1:0]          c_s1;
	logic [ROW_W-1:0]          r_s1;
	logic                      interior_s1, border_s1, last_s1;
	logic [pgm_pkg::SQ_W-1:0]  sq_dx_q, sq_dy_q;
	logic [pgm_pkg::PIX_W-1:0] mag_q;

	logic                      in_fire, out_fire;
	logic                      ram_wr_en, sqrt_start, sqrt_done;
	logic [pgm_pkg::PIX_W-1:0] prev_rd, prev2_rd, sqrt_root;

	// clamped frame size
	logic [XW_W-1:0] cw_ext;
	logic [XH_W-1:0] ch_ext;
	logic [DW_W-1:0] w_use;
	logic [DH_W-1:0] h_use;

	always_comb begin
		cw_ext = XW_W'(width_q);
		ch_ext = XH_W'(height_q);
		if (cw_ext < XW_W'(pgm_pkg::MIN_DIM)) begin
			w_use = DW_W'(pgm_pkg::MIN_DIM);
		end else if (cw_ext > XW_W'(MAX_WIDTH)) begin
			w_use = DW_W'(MAX_WIDTH);
		end else begin
			w_use = DW_W'(cw_ext);
		end
		if (ch_ext < XH_W'(pgm_pkg::MIN_DIM)) begin
			h_use = DH_W'(pgm_pkg::MIN_DIM);
		end else if (ch_ext > XH_W'(MAX_HEIGHT)) begin
			h_use = DH_W'(MAX_HEIGHT);
		end else begin
			h_use = DH_W'(ch_ext);
		end
	end

	// position of the arriving pixel and of the one after it
	logic [COL_W-1:0] c0, c_cur, col_n;
	logic [ROW_W-1:0] r0, r_cur, row_n;
	logic [DH_W-1:0]  r1, rp1;
	logic [DW_W-1:0]  cp1;
	logic             interior_cur, border_cur, last_cur;

	always_comb begin
		c0 = frame_start ? '0 : col_q;
		r0 = frame_start ? '0 : row_q;
		if (DW_W'(c0) >= w_use) begin
			c_cur = '0;
			r1    = DH_W'(r0) + DH_W'(1);
		end else begin
			c_cur = c0;
			r1    = DH_W'(r0);
		end
		r_cur = (r1 >= h_use) ? '0 : ROW_W'(r1);

		cp1 = DW_W'(c_cur) + DW_W'(1);
		rp1 = DH_W'(r_cur) + DH_W'(1);
		if (cp1 >= w_use) begin
			col_n = '0;
			row_n = (rp1 >= h_use) ? '0 : ROW_W'(rp1);
		end else begin
			col_n = COL_W'(cp1);
			row_n = r_cur;
		end

		interior_cur = (DH_W'(r_cur) >= DH_W'(2)) && (DW_W'(c_cur) >= DW_W'(2));
		last_cur     = (DH_W'(r_cur) == h_use - DH_W'(1)) &&
		               (DW_W'(c_cur) == w_use - DW_W'(1));
		border_cur   = (r_cur == '0) || (c_cur == '0) ||
		               (DH_W'(r_cur) == h_use - DH_W'(1)) ||
		               (DW_W'(c_cur) == w_use - DW_W'(1));
	end

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pgm_pkg::WIDTH_RESET;
			height_q <= pgm_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pgm_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				pgm_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position counters and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgm_pkg::S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				col_q <= col_n;
				row_q <= row_n;
			end
		end
	end

	// window shift, one column in per pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (state_q == pgm_pkg::S_WIN) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]     <= win_q[i*3 + 1];
				win_q[i*3 + 1] <= win_q[i*3 + 2];
			end
			win_q[2] <= prev2_rd;
			win_q[5] <= prev_rd;
			win_q[8] <= px_s1;
		end
	end

	// pixel beat capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1       <= pixel;
			c_s1        <= c_cur;
			r_s1        <= r_cur;
			interior_s1 <= interior_cur;
			border_s1   <= border_cur;
			last_s1     <= last_cur;
		end
	end

	// gradient sums and squares from the updated window
	logic [PSUM_W-1:0] sum_bot, sum_top, sum_rgt, sum_lft;
	logic [DIFF_W-1:0] dx, dy;
	logic [PSUM_W-1:0] abs_dx, abs_dy;

	always_comb begin
		sum_top = PSUM_W'(win_q[0]) + PSUM_W'(win_q[1]) + PSUM_W'(win_q[2]);
		sum_bot = PSUM_W'(win_q[6]) + PSUM_W'(win_q[7]) + PSUM_W'(win_q[8]);
		sum_lft = PSUM_W'(win_q[0]) + PSUM_W'(win_q[3]) + PSUM_W'(win_q[6]);
		sum_rgt = PSUM_W'(win_q[2]) + PSUM_W'(win_q[5]) + PSUM_W'(win_q[8]);
		dx      = DIFF_W'(sum_bot) - DIFF_W'(sum_top);
		dy      = DIFF_W'(sum_rgt) - DIFF_W'(sum_lft);
		abs_dx  = dx[DIFF_W-1] ? PSUM_W'(-dx) : PSUM_W'(dx);
		abs_dy  = dy[DIFF_W-1] ? PSUM_W'(-dy) : PSUM_W'(dy);
	end

	always_ff @(posedge clk) begin
		if (state_q == pgm_pkg::S_MUL) begin
			sq_dx_q <= pgm_pkg::SQ_W'(abs_dx) * pgm_pkg::SQ_W'(abs_dx);
			sq_dy_q <= pgm_pkg::SQ_W'(abs_dy) * pgm_pkg::SQ_W'(abs_dy);
		end
		if (sqrt_done) begin
			mag_q <= sqrt_root;
		end
	end

	// line rams: read at the pixel beat, write back the shifted column in the cycle after it
	pgm_ram #(
		.WIDTH (pgm_pkg::PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_prev (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (c_s1),
		.wr_data (px_s1),
		.rd_en   (in_fire),
		.rd_addr (c_cur),
		.rd_data (prev_rd)
	);

	pgm_ram #(
		.WIDTH (pgm_pkg::PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_prev2 (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (c_s1),
		.wr_data (prev_rd),
		.rd_en   (in_fire),
		.rd_addr (c_cur),
		.rd_data (prev2_rd)
	);

	// square root of the summed squares
	pgm_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand (pgm_pkg::SUM_W'(sq_dx_q) + pgm_pkg::SUM_W'(sq_dy_q)),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pgm_pkg::S_IDLE: begin
				if (in_fire) state_d = pgm_pkg::S_WIN;
			end
			pgm_pkg::S_WIN: begin
				priority if (interior_s1) state_d = pgm_pkg::S_MUL;
				else if (border_s1)       state_d = pgm_pkg::S_OUT_B;
				else                      state_d = pgm_pkg::S_IDLE;
			end
			pgm_pkg::S_MUL:     state_d = pgm_pkg::S_SQRT_GO;
			pgm_pkg::S_SQRT_GO: state_d = pgm_pkg::S_SQRT_WAIT;
			pgm_pkg::S_SQRT_WAIT: begin
				if (sqrt_done) state_d = pgm_pkg::S_OUT_I;
			end
			pgm_pkg::S_OUT_I: begin
				if (out_fire) state_d = border_s1 ? pgm_pkg::S_OUT_B : pgm_pkg::S_IDLE;
			end
			pgm_pkg::S_OUT_B: begin
				if (out_fire) state_d = pgm_pkg::S_IDLE;
			end
			default: state_d = pgm_pkg::S_IDLE;
		endcase
	end

	// outputs by state
	always_comb begin
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		ram_wr_en  = 1'b0;
		sqrt_start = 1'b0;
		out_row    = pgm_pkg::COORD_W'(r_s1);
		out_col    = pgm_pkg::COORD_W'(c_s1);
		magnitude  = '0;
		run_last   = 1'b1;
		frame_done = last_s1;
		unique case (state_q)
			pgm_pkg::S_IDLE:      in_ready   = 1'b1;
			pgm_pkg::S_WIN:       ram_wr_en  = 1'b1;
			pgm_pkg::S_MUL:       ;
			pgm_pkg::S_SQRT_GO:   sqrt_start = 1'b1;
			pgm_pkg::S_SQRT_WAIT: ;
			pgm_pkg::S_OUT_I: begin
				out_valid  = 1'b1;
				out_row    = pgm_pkg::COORD_W'(r_s1 - ROW_W'(1));
				out_col    = pgm_pkg::COORD_W'(c_s1 - COL_W'(1));
				magnitude  = mag_q;
				run_last   = !border_s1;
				frame_done = last_s1 && !border_s1;
			end
			pgm_pkg::S_OUT_B:     out_valid  = 1'b1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/pgm_ram.sv
// generic simple dual port ram with one write port and one registered read port
// standalone, no package dependency
`default_nettype none

module pgm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pgm_sqrt.sv
// iterative integer square root, one result bit per step, saturating to 255
// depends on pgm_pkg for widths and the saturation value
`default_nettype none

module pgm_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pgm_pkg::SUM_W-1:0]     operand,
	output      logic                          done,
	output      logic [pgm_pkg::PIX_W-1:0]     root
);

	logic                         busy_q;
	logic [pgm_pkg::ROOT_W-1:0]   rem_q;
	logic [pgm_pkg::ROOT_W-1:0]   root_q;
	logic [pgm_pkg::ROOT_W-1:0]   bit_q;
	logic [pgm_pkg::ROOT_W-1:0]   trial;
	logic                         sat;

	assign trial = root_q + bit_q;
	assign sat   = (operand[pgm_pkg::SUM_W-1:pgm_pkg::ROOT_W] != '0);
	assign done  = busy_q && (bit_q == '0);
	assign root  = root_q[pgm_pkg::PIX_W-1:0];

	// busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// one restoring step per cycle; bit moves down two places each step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= operand[pgm_pkg::ROOT_W-1:0];
			if (sat) begin
				root_q <= pgm_pkg::ROOT_W'(pgm_pkg::MAG_SAT);
				bit_q  <= '0;
			end else begin
				root_q <= '0;
				bit_q  <= pgm_pkg::ROOT_W'(1) << (pgm_pkg::ROOT_W - 2);
			end
		end else if (busy_q && (bit_q != '0)) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

`default_nettype wire
